@@ rtl/imbe_pkg.sv @@
package imbe_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_RDACK = 3'd3,
    CMD_RDNAK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUS_BUSY = 2'd1,
    ST_NO_START = 2'd2
  } status_t;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd20;

  // step numbers with a fixed meaning
  localparam logic [4:0] STEP_FIRST_ACK = 5'd16;
  localparam logic [4:0] STEP_ACK_MID   = 5'd17;
  localparam logic [4:0] STEP_ACK_HIGH  = 5'd18;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       sda_in;
  } imbe_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic [1:0] status;
  } imbe_out_t;

  // number of bus phases of each command
  function automatic logic [4:0] phase_total(input cmd_t cmd);
    case (cmd)
      CMD_START: phase_total = 5'd3;
      CMD_WRITE: phase_total = 5'd20;
      CMD_RDACK: phase_total = 5'd20;
      CMD_RDNAK: phase_total = 5'd19;
      CMD_STOP:  phase_total = 5'd3;
      default:   phase_total = 5'd0;
    endcase
  endfunction

endpackage

@@ rtl/i2c_master_byte_engine.sv @@
// I2C master byte engine. Each accepted input transaction is one tick of the
// bus timing: it carries the sampled SDA level and, while the engine is idle,
// an optional command (start, write with acknowledge check, read then ACK,
// read then NACK, stop). Every tick gives exactly one result transaction with
// the SCL/SDA drive levels (1 released, 0 pulled low), busy and done flags,
// the last received byte, the last write acknowledge and the status of the
// last command. Each bus phase lasts phase_ticks ticks (0 acts as 1); it must be
// written through the cfg port only while no command is running, which the block
// itself does not enforce. Throughput is one tick per clock cycle: the sequencer
// state updates in the cycle a tick is accepted and the result lands in a
// two-entry output buffer (output register plus skid register); input stall only
// rises once both entries hold results the consumer has not taken.
module i2c_master_byte_engine
  import imbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  imbe_in_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output imbe_out_t   out_data,
  // phase length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [15:0] phase_ticks;

  // sequencer state
  cmd_t        cmd;
  logic [4:0]  step;
  logic [15:0] phase_count;
  logic [7:0]  shift_byte;
  logic        scl_level;
  logic        sda_level;
  status_t     last_status;
  logic [7:0]  rx_hold;
  logic        ack_hold;

  cmd_t        cmd_next;
  logic [4:0]  step_next;
  logic [15:0] phase_count_next;
  logic [7:0]  shift_byte_next;
  logic        scl_level_next;
  logic        sda_level_next;
  status_t     last_status_next;
  logic [7:0]  rx_hold_next;
  logic        ack_hold_next;
  logic        done;

  // output buffer
  logic        skid_valid;
  imbe_out_t   skid_data;
  imbe_out_t   result;

  logic        in_accept;
  logic        out_accept;

  assign cfg_ready  = 1'b1;
  assign in_stall   = skid_valid;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // bus levels of one phase: {scl, sda}
  function automatic logic [1:0] phase_levels(input cmd_t c, input logic [4:0] s,
                                              input logic [7:0] sb, input logic scl_cur);
    logic [1:0] lv;
    lv = {scl_cur, 1'b1};
    case (c)
      CMD_START: begin
        if (s == 5'd0) lv = 2'b11;
        else if (s == 5'd1) lv = 2'b10;
        else lv = 2'b00;
      end
      CMD_WRITE: begin
        // msb first: bit 7 - s/2
        if (!s[4]) lv = {s[0], sb[~s[3:1]]};
        else if (s == STEP_ACK_HIGH) lv = 2'b11;
        else lv = 2'b01;
      end
      CMD_RDACK: begin
        if (!s[4]) lv = {s[0], 1'b1};
        else if (s == STEP_FIRST_ACK) lv = 2'b01;
        else if (s == STEP_ACK_MID) lv = 2'b00;
        else if (s == STEP_ACK_HIGH) lv = 2'b10;
        else lv = 2'b00;
      end
      CMD_RDNAK: begin
        if (!s[4]) lv = {s[0], 1'b1};
        else if (s == STEP_ACK_MID) lv = 2'b11;
        else lv = 2'b01;
      end
      CMD_STOP: begin
        if (s == 5'd0) lv = {scl_cur, 1'b0};
        else if (s == 5'd1) lv = 2'b10;
        else lv = 2'b11;
      end
      default: lv = {scl_cur, 1'b1};
    endcase
    return lv;
  endfunction

  // next state of the sequencer for the tick at the input
  always_comb begin
    logic [15:0] ticks;
    logic [16:0] count_inc;
    logic        abort;
    status_t     abort_status;
    logic        finish;
    logic [1:0]  lv;

    ticks            = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    count_inc        = {1'b0, phase_count} + 17'd1;
    abort            = 1'b0;
    abort_status     = ST_OK;
    finish           = 1'b0;
    lv               = 2'b11;

    cmd_next         = cmd;
    step_next        = step;
    phase_count_next = phase_count;
    shift_byte_next  = shift_byte;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    last_status_next = last_status;
    rx_hold_next     = rx_hold;
    ack_hold_next    = ack_hold;
    done             = 1'b0;

    if (cmd == CMD_IDLE) begin
      // commands 6 and 7 are plain ticks
      if (in_data.func >= CMD_START && in_data.func <= CMD_STOP) begin
        cmd_next         = cmd_t'(in_data.func);
        step_next        = 5'd0;
        phase_count_next = 16'd0;
        shift_byte_next  = (cmd_t'(in_data.func) == CMD_WRITE) ? in_data.tx_byte : 8'd0;
        lv = phase_levels(cmd_t'(in_data.func), 5'd0, shift_byte_next, scl_level);
        scl_level_next   = lv[1];
        sda_level_next   = lv[0];
      end
    end else if (count_inc >= {1'b0, ticks}) begin
      // end of the current phase: sample sda where needed
      phase_count_next = 16'd0;
      case (cmd)
        CMD_START: begin
          if (step == 5'd0 && !in_data.sda_in) begin
            abort        = 1'b1;
            abort_status = ST_BUS_BUSY;
          end else if (step == 5'd1 && in_data.sda_in) begin
            abort        = 1'b1;
            abort_status = ST_NO_START;
          end
        end
        CMD_WRITE: begin
          if (step == STEP_ACK_HIGH) ack_hold_next = ~in_data.sda_in;
        end
        CMD_RDACK, CMD_RDNAK: begin
          if (!step[4] && step[0]) shift_byte_next = {shift_byte[6:0], in_data.sda_in};
        end
        default: ;
      endcase

      if (abort) begin
        finish = 1'b1;
      end else begin
        step_next = step + 5'd1;
        if (step_next >= phase_total(cmd)) begin
          finish = 1'b1;
        end else begin
          lv             = phase_levels(cmd, step_next, shift_byte_next, scl_level);
          scl_level_next = lv[1];
          sda_level_next = lv[0];
        end
      end

      if (finish) begin
        if (cmd == CMD_RDACK || cmd == CMD_RDNAK) rx_hold_next = shift_byte_next;
        // release sda after the ack
        if (cmd == CMD_RDACK) sda_level_next = 1'b1;
        last_status_next = abort_status;
        cmd_next         = CMD_IDLE;
        done             = 1'b1;
      end
    end else begin
      phase_count_next = count_inc[15:0];
    end
  end

  assign result = '{
    scl_out:  scl_level_next,
    sda_out:  sda_level_next,
    busy_res: (cmd_next != CMD_IDLE),
    done_res: done,
    rx_byte:  rx_hold_next,
    ack_seen: ack_hold_next,
    status:   last_status_next
  };

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd         <= CMD_IDLE;
      step        <= 5'd0;
      phase_count <= 16'd0;
      shift_byte  <= 8'd0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      last_status <= ST_OK;
      rx_hold     <= 8'd0;
      ack_hold    <= 1'b0;
    end else if (in_accept) begin
      cmd         <= cmd_next;
      step        <= step_next;
      phase_count <= phase_count_next;
      shift_byte  <= shift_byte_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      last_status <= last_status_next;
      rx_hold     <= rx_hold_next;
      ack_hold    <= ack_hold_next;
    end
  end

  // two-entry output buffer: output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (out_valid && out_stall) begin
        // consumer holding the current result: park the new one
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_accept) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (out_valid && out_stall) skid_data <= result;
      else out_data <= result;
    end else if (out_accept && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // skid entry is only ever filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with output register empty");

  // a tick taken while the output is stalled must land in the skid register
  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_accept && out_valid && out_stall) |=> skid_valid)
    else $error("result lost while output stalled");

  // a finishing tick never reports the engine as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done and busy flagged together");

  // the step counter stays inside the phases of the current command
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (cmd != CMD_IDLE) |-> (step < phase_total(cmd)))
    else $error("step index beyond the last phase");

endmodule
